@@ hdl/text_console_char_writer_unit_assert.svh @@
// assertion macros used by the console writer top level
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only while out of reset
`define TCCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TCCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCCW_ASSERT(lbl, prop, msg)
`define TCCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/tccw_pkg.sv @@
// package: geometry, codes and item layouts of the text console writer
`timescale 1ns / 1ps
package tccw_pkg;

    // screen geometry
    localparam int WIDTH  = 80;
    localparam int HEIGHT = 25;
    localparam int CELLS  = WIDTH * HEIGHT;
    localparam int COPY_N = WIDTH * (HEIGHT - 1);

    localparam int COL_W  = $clog2(WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    // field widths
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = 16;
    localparam int POS_X_W  = 7;
    localparam int POS_Y_W  = 5;
    localparam int OFF_W    = 11;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7f;

    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h17;
    localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CH_SPACE};

    localparam int TAB_STOP = 8;
    localparam int TAB_SH   = $clog2(TAB_STOP);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_GOTO  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [POS_Y_W-1:0] pos_y;
        logic [POS_X_W-1:0] pos_x;
        logic [CHAR_W-1:0]  char_code;
        logic [CMD_W-1:0]   command;
    } in_item_t;

    typedef struct packed {
        logic               scrolled;
        logic [CELL_W-1:0]  cell_data;
        logic [OFF_W-1:0]   cursor_offset;
        logic [POS_Y_W-1:0] cursor_y;
        logic [POS_X_W-1:0] cursor_x;
    } out_item_t;

    localparam int IN_TDATA_W  = (($bits(in_item_t) + 7) / 8) * 8;
    localparam int OUT_TDATA_W = (($bits(out_item_t) + 7) / 8) * 8;

endpackage

@@ hdl/tccw_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module tccw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/tccw_addr_unit.sv @@
// shared cell address unit: row * width + column
`timescale 1ns / 1ps
module tccw_addr_unit (
    input  logic [tccw_pkg::ROW_W-1:0]  row,
    input  logic [tccw_pkg::COL_W-1:0]  col,
    output logic [tccw_pkg::ADDR_W-1:0] addr
);
    import tccw_pkg::*;

    assign addr = ADDR_W'(32'(row) * WIDTH + 32'(col));

endmodule

@@ hdl/text_console_char_writer_unit.sv @@
// top level: text console character writer with screen memory and cursor
// sequence: put and goto run idle, exec, done; a read adds a wait state for the ram read;
//   a put that scrolls copies the rows up, then blanks the bottom row; clear blanks every cell
// requests: a new one is taken only in idle, after the sequencer has stepped the last one
//   through the single-port-per-direction screen ram
// reset: cursor to home, attribute 0x17, then a clearing pass writes 0x1720 to every cell
//   with s_axis_tready low; config writes are taken meanwhile
`timescale 1ns / 1ps
`include "text_console_char_writer_unit_assert.svh"
module text_console_char_writer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // request: command[1:0], char_code[9:2], pos_x[16:10], pos_y[21:17], zero pad
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tccw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // result: cursor_x[6:0], cursor_y[11:7], cursor_offset[22:12],
    //         cell_data[38:23], scrolled[39]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tccw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // attribute register write
    input  logic                             cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0]      cfg_wdata
);
    import tccw_pkg::*;

    // sequencer state and cursor
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               scrolled_reg, scrolled_next;
    logic [ATTR_W-1:0]  attr_reg;

    // latched request (payload, no reset)
    cmd_t               cmd_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COL_W-1:0]   px_reg;
    logic [ROW_W-1:0]   py_reg;
    logic [CELL_W-1:0]  cell_reg;

    // result register
    logic               out_valid_reg;
    out_item_t          out_data_reg;
    logic               out_load;

    in_item_t           in_item;
    logic               in_acc;
    logic [COL_W-1:0]   px_clamp;
    logic [ROW_W-1:0]   py_clamp;

    // shared address unit operands
    logic [ROW_W-1:0]   unit_row;
    logic [COL_W-1:0]   unit_col;
    logic [ADDR_W-1:0]  unit_addr;

    // screen ram ports
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    // put-byte decode
    logic [CELL_W-1:0]  blank;
    logic [COL_W:0]     col_inc;
    logic [COL_W:0]     tab_col;
    logic [ROW_W:0]     row_inc;
    logic [COL_W-1:0]   p_col;
    logic [ROW_W:0]     p_row;
    logic               p_we;
    logic               p_bs;
    logic [CELL_W-1:0]  p_wdata;
    logic [COL_W-1:0]   bs_col;
    logic [ROW_W-1:0]   bs_row;

    assign in_item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // goto and read positions saturate to the screen edges
    assign px_clamp = (32'(in_item.pos_x) >= WIDTH) ? COL_W'(WIDTH - 1)
                                                    : COL_W'(in_item.pos_x);
    assign py_clamp = (32'(in_item.pos_y) >= HEIGHT) ? ROW_W'(HEIGHT - 1)
                                                     : ROW_W'(in_item.pos_y);

    // blank cell uses the current attribute
    assign blank = {attr_reg, CH_SPACE};

    tccw_addr_unit u_addr (
        .row  (unit_row),
        .col  (unit_col),
        .addr (unit_addr)
    );

    tccw_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // cursor motion for one put byte
    always_comb
    begin
        col_inc = {1'b0, col_reg} + (COL_W + 1)'(1);
        tab_col = (COL_W + 1)'({col_reg[COL_W-1:TAB_SH], {TAB_SH{1'b0}}})
                + (COL_W + 1)'(TAB_STOP);
        row_inc = {1'b0, row_reg} + (ROW_W + 1)'(1);

        // backspace target: step back, wrap to end of previous row, stay at home
        bs_col = col_reg;
        bs_row = row_reg;
        if (col_reg != '0)
        begin
            bs_col = col_reg - COL_W'(1);
        end
        else if (row_reg != '0)
        begin
            bs_row = row_reg - ROW_W'(1);
            bs_col = COL_W'(WIDTH - 1);
        end

        p_col   = col_reg;
        p_row   = {1'b0, row_reg};
        p_we    = 1'b0;
        p_bs    = 1'b0;
        p_wdata = {attr_reg, char_reg};

        case (char_reg)
            CH_LF:
            begin
                p_col = '0;
                p_row = row_inc;
            end
            CH_CR:
            begin
                p_col = '0;
            end
            CH_TAB:
            begin
                // tab that reaches the line end wraps
                if (tab_col >= (COL_W + 1)'(WIDTH))
                begin
                    p_col = '0;
                    p_row = row_inc;
                end
                else
                begin
                    p_col = tab_col[COL_W-1:0];
                end
            end
            CH_BS:
            begin
                p_col   = bs_col;
                p_row   = {1'b0, bs_row};
                p_we    = 1'b1;
                p_bs    = 1'b1;
                p_wdata = blank;
            end
            default:
            begin
                // other control bytes and bytes above 127 are dropped
                if (char_reg inside {[CH_SPACE:CH_DEL]})
                begin
                    p_we = 1'b1;
                    if (col_inc >= (COL_W + 1)'(WIDTH))
                    begin
                        p_col = '0;
                        p_row = row_inc;
                    end
                    else
                    begin
                        p_col = col_inc[COL_W-1:0];
                    end
                end
            end
        endcase
    end

    // sequencer: next state, ram control, address unit operand select
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        scrolled_next = scrolled_reg;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg[ADDR_W-1:0];
        ram_wdata     = blank;
        ram_raddr     = unit_addr;
        unit_row      = row_reg;
        unit_col      = col_reg;

        case (state_reg)
            ST_INIT:
            begin
                // power-up clear with the reset attribute
                ram_we    = 1'b1;
                ram_wdata = RESET_BLANK;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    scrolled_next = 1'b0;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (cmd_reg)
                    CMD_PUT:
                    begin
                        // printable writes at the old cursor, backspace at the new one
                        unit_row  = p_bs ? bs_row : row_reg;
                        unit_col  = p_bs ? bs_col : col_reg;
                        ram_we    = p_we;
                        ram_waddr = unit_addr;
                        ram_wdata = p_wdata;
                        col_next  = p_col;
                        if (p_row == (ROW_W + 1)'(HEIGHT))
                        begin
                            row_next      = ROW_W'(HEIGHT - 1);
                            scrolled_next = 1'b1;
                            cnt_next      = '0;
                            state_next    = ST_SCROLL;
                        end
                        else
                        begin
                            row_next   = p_row[ROW_W-1:0];
                            state_next = ST_DONE;
                        end
                    end
                    CMD_GOTO:
                    begin
                        col_next   = px_reg;
                        row_next   = py_reg;
                        state_next = ST_DONE;
                    end
                    CMD_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end
                    CMD_READ:
                    begin
                        unit_row   = py_reg;
                        unit_col   = px_reg;
                        ram_raddr  = unit_addr;
                        state_next = ST_RD_WAIT;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_SCROLL:
            begin
                // read one row below, write back in the next cycle
                ram_raddr = ADDR_W'(cnt_reg + CNT_W'(WIDTH));
                ram_we    = (cnt_reg != '0);
                ram_waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                ram_wdata = ram_rdata;
                if (cnt_reg == CNT_W'(COPY_N))
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                // address unit gives the cursor offset here
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            scrolled_reg <= scrolled_next;
        end
    end

    // attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_we)
        begin
            attr_reg <= cfg_wdata;
        end
    end

    // request latch and read data capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg  <= cmd_t'(in_item.command);
            char_reg <= in_item.char_code;
            px_reg   <= px_clamp;
            py_reg   <= py_clamp;
            cell_reg <= '0;
        end
        else if (state_reg == ST_RD_WAIT)
        begin
            cell_reg <= ram_rdata;
        end
    end

    // result register, lets the next request in while a result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.cursor_x      <= POS_X_W'(col_reg);
            out_data_reg.cursor_y      <= POS_Y_W'(row_reg);
            out_data_reg.cursor_offset <= OFF_W'(unit_addr);
            out_data_reg.cell_data     <= cell_reg;
            out_data_reg.scrolled      <= scrolled_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    `TCCW_ASSERT(a_cursor_in_range, (32'(row_reg) < HEIGHT) && (32'(col_reg) < WIDTH), "cursor left the screen")
    `TCCW_ASSERT(a_no_result_in_init, (state_reg == ST_INIT) |-> !out_valid_reg, "result during power-up clear")
    `TCCW_ASSERT(a_scroll_copy_bound, ((state_reg == ST_SCROLL) && ram_we) |-> (32'(ram_waddr) < COPY_N), "scroll copy wrote the bottom row")
    `TCCW_ASSERT(a_scrolled_on_last_row, (out_valid_reg && out_data_reg.scrolled) |-> (32'(out_data_reg.cursor_y) == HEIGHT - 1), "scroll left cursor off the last row")

endmodule

@@ tb/tb_top.sv @@
// testbench for the text console writer: directed and random command streams, self-checking
`timescale 1ns / 1ps
module tb_top;
    import tccw_pkg::*;

    // random part: phases of requests, a new attribute before each phase
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 90;
    // the receiver stops taking results for a long stretch once this many have arrived
    localparam int HOLD_AFTER    = 120;
    localparam int HOLD_CYCLES   = 400;
    // cycles to let pass once every result has arrived
    localparam int TAIL_CYCLES   = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // request: command, char_code, pos_x, pos_y, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // result: cursor_x, cursor_y, cursor_offset, cell_data, scrolled
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [ATTR_W-1:0]      cfg_wdata;

    // scoreboard: keeps its own screen, cursor and attribute, and the results still owed
    class screen_tracker;
        logic [CELL_W-1:0] cells [CELLS];
        int                cur_col;
        int                cur_row;
        logic [ATTR_W-1:0] attr;
        out_item_t         awaited [$];
        int                mismatches;
        int                results_checked;

        function new();
            foreach (cells[i])
                cells[i] = RESET_BLANK;
            cur_col         = 0;
            cur_row         = 0;
            attr            = ATTR_RESET;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function void fill_blank(int from, int upto);
            for (int i = from; i < upto; i++)
                cells[i] = {attr, CH_SPACE};
        endfunction

        // one byte of a put request: moves the cursor, may write a cell;
        // the row may end up at HEIGHT, the caller scrolls
        function void put_char(logic [CHAR_W-1:0] ch);
            case (ch)
                CH_LF:
                begin
                    cur_row++;
                    cur_col = 0;
                end
                CH_CR:
                    cur_col = 0;
                CH_TAB:
                begin
                    cur_col += TAB_STOP - (cur_col % TAB_STOP);
                    // a tab reaching the line end wraps to the next row
                    if (cur_col >= WIDTH)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                CH_BS:
                begin
                    // step back, wrap to the previous row end, stay put at home
                    if (cur_col > 0)
                        cur_col--;
                    else if (cur_row > 0)
                    begin
                        cur_row--;
                        cur_col = WIDTH - 1;
                    end
                    cells[cur_row * WIDTH + cur_col] = {attr, CH_SPACE};
                end
                default:
                begin
                    // control bytes and the upper half are ignored, 0x7f is printable
                    if (ch >= CH_SPACE && ch <= CH_DEL)
                    begin
                        cells[cur_row * WIDTH + cur_col] = {attr, ch};
                        cur_col++;
                        if (cur_col >= WIDTH)
                        begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                end
            endcase
        endfunction

        // accepted request: update the screen and queue the result it owes
        function void note_request(in_item_t req);
            out_item_t want;
            int        px;
            int        py;
            want = '0;
            // goto and read positions saturate at the screen edge
            px = (req.pos_x >= WIDTH) ? WIDTH - 1 : int'(req.pos_x);
            py = (req.pos_y >= HEIGHT) ? HEIGHT - 1 : int'(req.pos_y);
            case (req.command)
                CMD_PUT:
                begin
                    put_char(req.char_code);
                    // moved past the last row: scroll up, blank the bottom row
                    if (cur_row >= HEIGHT)
                    begin
                        for (int i = 0; i < COPY_N; i++)
                            cells[i] = cells[i + WIDTH];
                        fill_blank(COPY_N, CELLS);
                        cur_row        = HEIGHT - 1;
                        want.scrolled  = 1'b1;
                    end
                end
                CMD_GOTO:
                begin
                    cur_col = px;
                    cur_row = py;
                end
                CMD_CLEAR:
                begin
                    fill_blank(0, CELLS);
                    cur_col = 0;
                    cur_row = 0;
                end
                default:
                    want.cell_data = cells[py * WIDTH + px];
            endcase
            want.cursor_x      = POS_X_W'(cur_col);
            want.cursor_y      = POS_Y_W'(cur_row);
            want.cursor_offset = OFF_W'(cur_row * WIDTH + cur_col);
            awaited.push_back(want);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // accepted result: compare with the oldest one owed
        function void check_result(out_item_t got);
            out_item_t want;
            results_checked++;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with none owed, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            check_field("cursor_x", 32'(want.cursor_x), 32'(got.cursor_x));
            check_field("cursor_y", 32'(want.cursor_y), 32'(got.cursor_y));
            check_field("cursor_offset", 32'(want.cursor_offset), 32'(got.cursor_offset));
            check_field("cell_data", 32'(want.cell_data), 32'(got.cell_data));
            check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
        endfunction
    endclass

    screen_tracker sb = new();

    // sender burst bookkeeping
    int burst_left;

    text_console_char_writer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit, far above the slowest correct run (every request scrolling,
    // every result stalled, every sender gap at its longest)
    initial
    begin
        #(50_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic in_item_t make_req(cmd_t cmd, logic [CHAR_W-1:0] ch,
                                          logic [POS_X_W-1:0] x, logic [POS_Y_W-1:0] y);
        in_item_t req;
        req.command   = cmd;
        req.char_code = ch;
        req.pos_x     = x;
        req.pos_y     = y;
        return req;
    endfunction

    // random request, weighted toward puts; gotos lean to the bottom rows so
    // that scrolls happen, reads lean to the cursor row where text lands
    function automatic in_item_t random_request();
        in_item_t req;
        int       pick;
        int       sel;
        int       row;
        req.command   = CMD_PUT;
        req.char_code = CHAR_W'($urandom_range(0, 255));
        req.pos_x     = POS_X_W'($urandom_range(0, 127));
        req.pos_y     = POS_Y_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        if (pick < 68)
        begin
            if (sel < 55)
                req.char_code = CHAR_W'($urandom_range(CH_SPACE, CH_DEL));
            else if (sel < 63)
                req.char_code = CH_LF;
            else if (sel < 68)
                req.char_code = CH_CR;
            else if (sel < 76)
                req.char_code = CH_TAB;
            else if (sel < 84)
                req.char_code = CH_BS;
            else if (sel < 92)
                req.char_code = CHAR_W'($urandom_range(0, CH_SPACE - 1));
            else
                req.char_code = CHAR_W'($urandom_range(128, 255));
        end
        else if (pick < 80)
        begin
            req.command = CMD_GOTO;
            if (sel < 40)
            begin
                req.pos_x = POS_X_W'($urandom_range(0, WIDTH - 1));
                req.pos_y = POS_Y_W'($urandom_range(HEIGHT - 3, HEIGHT - 1));
            end
            else if (sel < 80)
            begin
                req.pos_x = POS_X_W'($urandom_range(0, WIDTH - 1));
                req.pos_y = POS_Y_W'($urandom_range(0, HEIGHT - 1));
            end
        end
        else if (pick < 97)
        begin
            req.command = CMD_READ;
            if (sel < 60)
            begin
                row = sb.cur_row - int'($urandom_range(0, 1));
                req.pos_x = POS_X_W'($urandom_range(0, WIDTH - 1));
                req.pos_y = (row < 0) ? '0 : POS_Y_W'(row);
            end
            else if (sel < 85)
            begin
                req.pos_x = POS_X_W'($urandom_range(0, WIDTH - 1));
                req.pos_y = POS_Y_W'($urandom_range(0, HEIGHT - 1));
            end
        end
        else
            req.command = CMD_CLEAR;
        return req;
    endfunction

    // offer one request, in bursts with random gaps, and wait for it to be taken
    task automatic send_request(input in_item_t req);
        logic [IN_TDATA_W-1:0] word;
        int                    gap;
        word = '0;
        word[$bits(in_item_t)-1:0] = req;
        if (burst_left == 0)
        begin
            // about a third of the bursts follow straight on
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(req);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // attribute write, only while the block is idle
    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.attr = value;
    endtask

    // result side: accept and check at every handshake
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[$bits(out_item_t)-1:0]);
    end

    // receiver ready pattern: modes of random length, from always ready to
    // rotating masks; once, a long hold-off so the block backs up its input
    initial
    begin : result_sink
        int          mode;
        int          mode_left;
        logic [7:0]  mask;
        bit          hold_done;
        m_axis_tready = 1'b0;
        mode          = 0;
        mode_left     = 0;
        mask          = 8'hff;
        hold_done     = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && sb.results_checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                    mask      = 8'($urandom_range(1, 255));
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:
                    begin
                        m_axis_tready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                    default: m_axis_tready <= 1'($urandom_range(0, 1));
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [ATTR_W-1:0] phase_attr [RANDOM_PHASES];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        burst_left    = 0;
        // all-ones, top-bit-only and reset attributes among the phase settings
        phase_attr[0] = 8'hff;
        phase_attr[1] = ATTR_W'($urandom_range(0, 255));
        phase_attr[2] = ATTR_RESET;
        phase_attr[3] = 8'h80;
        phase_attr[4] = ATTR_W'($urandom_range(0, 255));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // the block clears its screen after reset with input ready low
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        write_attribute(8'h00);

        // directed: reset screen, printable limits, ignored bytes, control bytes
        send_request(make_req(CMD_READ, 8'h00, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, 8'h41, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, CH_SPACE, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, CH_DEL, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, 8'h80, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, 8'hff, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, 8'h00, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, 8'h1f, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, CH_TAB, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, CH_BS, 7'd0, 5'd0));
        send_request(make_req(CMD_PUT, CH_CR, 7'd0, 5'd0));
        // backspace at home stays put and blanks the home cell
        send_request(make_req(CMD_PUT, CH_BS, 7'd0, 5'd0));
        send_request(make_req(CMD_READ, 8'h00, 7'd0, 5'd0));
        // saturated goto, then a put in the last cell wraps and scrolls
        send_request(make_req(CMD_GOTO, 8'h00, 7'd127, 5'd31));
        send_request(make_req(CMD_PUT, 8'h5a, 7'd0, 5'd0));
        send_request(make_req(CMD_READ, 8'h00, 7'd79, 5'd23));
        // tab reaching the line end on the bottom row wraps and scrolls
        send_request(make_req(CMD_GOTO, 8'h00, 7'd76, 5'd24));
        send_request(make_req(CMD_PUT, CH_TAB, 7'd0, 5'd0));
        // newline on the bottom row scrolls
        send_request(make_req(CMD_PUT, CH_LF, 7'd0, 5'd0));
        // backspace at a row start wraps to the previous row end
        send_request(make_req(CMD_GOTO, 8'h00, 7'd0, 5'd1));
        send_request(make_req(CMD_PUT, CH_BS, 7'd0, 5'd0));
        // saturated reads, just past the edge and at the field maximum
        send_request(make_req(CMD_READ, 8'h00, 7'd127, 5'd31));
        send_request(make_req(CMD_READ, 8'h00, 7'd80, 5'd25));
        // clear blanks with the current attribute and homes the cursor
        send_request(make_req(CMD_CLEAR, 8'h00, 7'd0, 5'd0));
        send_request(make_req(CMD_READ, 8'h00, 7'd0, 5'd0));
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_attribute(phase_attr[p]);
            repeat (PHASE_ITEMS) send_request(random_request());
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ text_console_char_writer_unit.f @@
+incdir+hdl
hdl/tccw_pkg.sv
hdl/tccw_ram.sv
hdl/tccw_addr_unit.sv
hdl/text_console_char_writer_unit.sv
tb/tb_top.sv
